/* rtl/psc_pkg.sv */
// Package for the pressure sensor compensation block.
// Shared constants, register codes and the pipeline item type; no dependencies.
`timescale 1ns / 1ps
package psc_pkg;

   localparam int DivStages = 32;

   typedef enum logic [1:0] {
      CSR_COEFF_A = 2'd0,
      CSR_COEFF_B = 2'd1,
      CSR_COEFF_C = 2'd2,
      CSR_OVERSAMPLING = 2'd3
   } csr_index_type;

   localparam logic [31:0] TempOffset = 32'd4000;
   localparam logic [31:0] PressCoefA = 32'd3038;
   localparam logic [31:0] PressCoefB = 32'hFFFF_E343; // -7357
   localparam logic [31:0] PressCoefC = 32'd3791;
   localparam logic [31:0] PressScale = 32'd50000;
   localparam logic [31:0] B4Bias = 32'd32768;

   typedef struct packed {
      logic [23:0] raw_p;
      logic        err;
      logic        flag;
      logic [15:0] tt;
      logic [31:0] ta;
      logic [31:0] tb;
      logic [31:0] tc;
      logic [31:0] td;
   } item_type;

   function automatic logic [31:0] sx16(input logic [15:0] x);
      return {{16{x[15]}}, x};
   endfunction

endpackage

/* rtl/psc_if.sv */
// Channel interfaces for the pressure sensor compensation block.
// Depends on nothing; carry valid, ready and the item payload.
`timescale 1ns / 1ps
interface psc_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] raw_temperature;
   logic [23:0] raw_pressure_bytes;
   modport source (output valid, raw_temperature, raw_pressure_bytes, input ready);
   modport sink (input valid, raw_temperature, raw_pressure_bytes, output ready);
endinterface

interface psc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] temperature_tenths;
   logic signed [31:0] pressure_pa;
   logic               divide_error;
   modport source (output valid, temperature_tenths, pressure_pa, divide_error,
                   input ready);
   modport sink (input valid, temperature_tenths, pressure_pa, divide_error,
                 output ready);
endinterface

/* rtl/psc_div.sv */
// Pipelined unsigned 32 by 32 divider, one quotient bit per stage.
// Uses psc_pkg for the item type carried alongside the operands.
`timescale 1ns / 1ps
module psc_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  psc_pkg::item_type in_item,
   input  logic [31:0]       in_dividend,
   input  logic [31:0]       in_divisor,
   output logic              out_valid,
   output psc_pkg::item_type out_item,
   output logic [31:0]       out_quotient
);

   localparam int N = psc_pkg::DivStages;

   logic              valid_ff [1:N];
   psc_pkg::item_type item_ff [1:N];
   logic [31:0]       rem_ff [1:N];
   logic [31:0]       num_ff [1:N];
   logic [31:0]       den_ff [1:N];
   logic [31:0]       quo_ff [1:N];

   for (genvar i = 0; i < N; i++) begin : g_stage
      logic              valid_cur;
      psc_pkg::item_type item_cur;
      logic [31:0]       rem_cur;
      logic [31:0]       num_cur;
      logic [31:0]       den_cur;
      logic [31:0]       quo_cur;
      logic [32:0]       trial;
      logic [32:0]       diff;
      logic              ge;
      logic [31:0]       rem_in;

      if (i == 0) begin : g_head
         assign valid_cur = in_valid;
         assign item_cur = in_item;
         assign rem_cur = '0;
         assign num_cur = in_dividend;
         assign den_cur = in_divisor;
         assign quo_cur = '0;
      end else begin : g_tail
         assign valid_cur = valid_ff[i];
         assign item_cur = item_ff[i];
         assign rem_cur = rem_ff[i];
         assign num_cur = num_ff[i];
         assign den_cur = den_ff[i];
         assign quo_cur = quo_ff[i];
      end

      always_comb begin
         trial = {rem_cur, num_cur[31]};
         diff = trial - {1'b0, den_cur};
         ge = (trial >= {1'b0, den_cur});
         rem_in = ge ? diff[31:0] : trial[31:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (enable) begin
            valid_ff[i+1] <= valid_cur;
         end
         if (enable) begin
            item_ff[i+1] <= item_cur;
            rem_ff[i+1] <= rem_in;
            num_ff[i+1] <= {num_cur[30:0], 1'b0};
            den_ff[i+1] <= den_cur;
            quo_ff[i+1] <= {quo_cur[30:0], ge};
         end
      end
   end

   assign out_valid = valid_ff[N];
   assign out_item = item_ff[N];
   assign out_quotient = quo_ff[N];

endmodule

/* rtl/pressure_sensor_compensation.sv */
// Top level of the pressure sensor compensation block.
// Depends on psc_pkg, psc_req_if, psc_rsp_if and psc_div.
//
// Usage:
//   req_ch carries one raw temperature word and three raw pressure bytes per item;
//   rsp_ch returns one item per request: temperature in tenths of a degree
//   (saturated), pressure in pascals and a divide error flag that zeroes both.
//   Calibration words and the oversampling setting are written through the csr_
//   port while no item is in flight; indexes beyond the register list are ignored.
//   An item passes 73 registers: nine arithmetic stages plus two 32-stage dividers,
//   one quotient bit per stage.
//   Throughput is one item per cycle while the receiver keeps rsp_ch.ready high.
//   Reset clears all valid bits and loads the registers (oversampling = 3).
//   When the receiver holds rsp_ch.ready low with a result waiting, the whole
//   pipeline freezes and req_ch.ready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
module pressure_sensor_compensation (
   input  logic        clock,
   input  logic        reset,
   psc_req_if.sink     req_ch,
   psc_rsp_if.source   rsp_ch,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data
);

   logic [63:0] coeff_a_ff;
   logic [63:0] coeff_b_ff;
   logic [31:0] coeff_c_ff;
   logic [1:0]  oss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_a_ff <= '0;
         coeff_b_ff <= '0;
         coeff_c_ff <= '0;
         oss_ff <= 2'd3;
      end else if (csr_write_enable) begin
         unique case (psc_pkg::csr_index_type'(csr_index))
            psc_pkg::CSR_COEFF_A: coeff_a_ff <= csr_write_data;
            psc_pkg::CSR_COEFF_B: coeff_b_ff <= csr_write_data;
            psc_pkg::CSR_COEFF_C: coeff_c_ff <= csr_write_data[31:0];
            psc_pkg::CSR_OVERSAMPLING: oss_ff <= csr_write_data[1:0];
            default: ;
         endcase
      end
   end

   logic [15:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   assign ac1 = coeff_a_ff[63:48];
   assign ac2 = coeff_a_ff[47:32];
   assign ac3 = coeff_a_ff[31:16];
   assign ac4 = coeff_a_ff[15:0];
   assign ac5 = coeff_b_ff[63:48];
   assign ac6 = coeff_b_ff[47:32];
   assign b1 = coeff_b_ff[31:16];
   assign b2 = coeff_b_ff[15:0];
   assign mc = coeff_c_ff[31:16];
   assign md = coeff_c_ff[15:0];

   logic out_valid_ff;
   logic enable;
   assign enable = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = enable;

   // stage A: temperature product
   logic              a_valid_ff;
   psc_pkg::item_type a_ff, a_in;
   logic [16:0]       a_diff;

   always_comb begin
      a_in = '0;
      a_diff = {1'b0, req_ch.raw_temperature} - {1'b0, ac6};
      a_in.raw_p = req_ch.raw_pressure_bytes;
      a_in.ta = {{15{a_diff[16]}}, a_diff} * {16'd0, ac5};
   end

   // divider one operands
   psc_pkg::item_type d1_item;
   logic [31:0]       d1_num, d1_den, x1t, numt, dent;

   always_comb begin
      x1t = 32'($signed(a_ff.ta) >>> 15);
      dent = x1t + psc_pkg::sx16(md);
      numt = psc_pkg::sx16(mc) << 11;
      d1_item = a_ff;
      d1_item.ta = x1t;
      d1_item.err = (dent == 32'd0);
      d1_item.flag = numt[31] ^ dent[31];
      d1_num = numt[31] ? (~numt + 32'd1) : numt;
      d1_den = dent[31] ? (~dent + 32'd1) : dent;
   end

   logic              q1_valid;
   psc_pkg::item_type q1_item;
   logic [31:0]       q1_quo;

   psc_div u_div_temp (
      .clock        (clock),
      .reset        (reset),
      .enable       (enable),
      .in_valid     (a_valid_ff),
      .in_item      (d1_item),
      .in_dividend  (d1_num),
      .in_divisor   (d1_den),
      .out_valid    (q1_valid),
      .out_item     (q1_item),
      .out_quotient (q1_quo)
   );

   // stage C: b5, temperature, b6
   logic              c_valid_ff;
   psc_pkg::item_type c_ff, c_in;
   logic [31:0]       c_x2, c_b5, c_t;

   always_comb begin
      c_in = q1_item;
      c_x2 = q1_item.flag ? (~q1_quo + 32'd1) : q1_quo;
      c_b5 = q1_item.ta + c_x2;
      c_t = 32'($signed(c_b5 + 32'd8) >>> 4);
      if ($signed(c_t) > 32'sd32767) begin
         c_in.tt = 16'h7FFF;
      end else if ($signed(c_t) < -32'sd32768) begin
         c_in.tt = 16'h8000;
      end else begin
         c_in.tt = c_t[15:0];
      end
      c_in.tb = c_b5 - psc_pkg::TempOffset;
   end

   // stage D: products of b6
   logic              d_valid_ff;
   psc_pkg::item_type d_ff, d_in;

   always_comb begin
      d_in = c_ff;
      d_in.ta = c_ff.tb * c_ff.tb;
      d_in.tb = psc_pkg::sx16(ac2) * c_ff.tb;
      d_in.tc = psc_pkg::sx16(ac3) * c_ff.tb;
   end

   // stage E: coefficient products of b6 squared and the scaled b6 products
   logic              e_valid_ff;
   psc_pkg::item_type e_ff, e_in;
   logic [31:0]       e_sq;

   always_comb begin
      e_in = d_ff;
      e_sq = 32'($signed(d_ff.ta) >>> 12);
      e_in.ta = psc_pkg::sx16(b2) * e_sq;
      e_in.td = psc_pkg::sx16(b1) * e_sq;
      e_in.tb = 32'($signed(d_ff.tb) >>> 11);
      e_in.tc = 32'($signed(d_ff.tc) >>> 13);
   end

   // stage F: b3 and the b4 factor
   logic              f_valid_ff;
   psc_pkg::item_type f_ff, f_in;
   logic [31:0]       f_x3, f_b3s, f_y, f_y3;

   always_comb begin
      f_in = e_ff;
      f_x3 = 32'($signed(e_ff.ta) >>> 11) + e_ff.tb;
      f_b3s = (((psc_pkg::sx16(ac1) << 2) + f_x3) << oss_ff) + 32'd2;
      f_in.ta = 32'($signed(f_b3s) >>> 2);
      f_y = e_ff.tc + 32'($signed(e_ff.td) >>> 16) + 32'd2;
      f_y3 = 32'($signed(f_y) >>> 2);
      f_in.tb = f_y3 + psc_pkg::B4Bias;
   end

   // stage G: b4 product and b7
   logic              g_valid_ff;
   psc_pkg::item_type g_ff, g_in;
   logic [31:0]       g_up;

   always_comb begin
      g_in = f_ff;
      g_up = {8'd0, f_ff.raw_p} >> (4'd8 - {2'd0, oss_ff});
      g_in.ta = {16'd0, ac4} * f_ff.tb;
      g_in.tb = (g_up - f_ff.ta) * (psc_pkg::PressScale >> oss_ff);
   end

   // divider two operands
   psc_pkg::item_type d2_item;
   logic [31:0]       d2_num, d2_den;

   always_comb begin
      d2_den = g_ff.ta >> 15;
      d2_item = g_ff;
      d2_item.err = g_ff.err || (d2_den == 32'd0);
      d2_item.flag = g_ff.tb[31];
      d2_num = g_ff.tb[31] ? g_ff.tb : {g_ff.tb[30:0], 1'b0};
   end

   logic              q2_valid;
   psc_pkg::item_type q2_item;
   logic [31:0]       q2_quo;

   psc_div u_div_press (
      .clock        (clock),
      .reset        (reset),
      .enable       (enable),
      .in_valid     (g_valid_ff),
      .in_item      (d2_item),
      .in_dividend  (d2_num),
      .in_divisor   (d2_den),
      .out_valid    (q2_valid),
      .out_item     (q2_item),
      .out_quotient (q2_quo)
   );

   // stage I: pressure products
   logic              i_valid_ff;
   psc_pkg::item_type i_ff, i_in;
   logic [31:0]       i_p, i_pp;

   always_comb begin
      i_in = q2_item;
      i_p = q2_item.flag ? {q2_quo[30:0], 1'b0} : q2_quo;
      i_pp = 32'($signed(i_p) >>> 8);
      i_in.ta = i_pp * i_pp;
      i_in.tb = psc_pkg::PressCoefB * i_p;
      i_in.tc = i_p;
   end

   // stage J: scale the correction terms
   logic              j_valid_ff;
   psc_pkg::item_type j_ff, j_in;
   logic [31:0]       j_m;

   always_comb begin
      j_in = i_ff;
      j_m = i_ff.ta * psc_pkg::PressCoefA;
      j_in.ta = 32'($signed(j_m) >>> 16);
      j_in.tb = 32'($signed(i_ff.tb) >>> 16);
   end

   // output register
   logic [15:0] temp_ff, temp_in;
   logic [31:0] press_ff, press_in, k_sum;
   logic        err_ff;

   always_comb begin
      k_sum = j_ff.ta + j_ff.tb + psc_pkg::PressCoefC;
      press_in = j_ff.tc + 32'($signed(k_sum) >>> 4);
      temp_in = j_ff.tt;
      if (j_ff.err) begin
         press_in = '0;
         temp_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
         i_valid_ff <= 1'b0;
         j_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         a_valid_ff <= req_ch.valid;
         c_valid_ff <= q1_valid;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
         f_valid_ff <= e_valid_ff;
         g_valid_ff <= f_valid_ff;
         i_valid_ff <= q2_valid;
         j_valid_ff <= i_valid_ff;
         out_valid_ff <= j_valid_ff;
      end
      if (enable) begin
         a_ff <= a_in;
         c_ff <= c_in;
         d_ff <= d_in;
         e_ff <= e_in;
         f_ff <= f_in;
         g_ff <= g_in;
         i_ff <= i_in;
         j_ff <= j_in;
         temp_ff <= temp_in;
         press_ff <= press_in;
         err_ff <= j_ff.err;
      end
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.temperature_tenths = temp_ff;
   assign rsp_ch.pressure_pa = press_ff;
   assign rsp_ch.divide_error = err_ff;

endmodule

/* verif/pressure_sensor_compensation_tb.sv */
// Testbench for pressure_sensor_compensation: random and directed readings under
// several calibration settings, checked against an in-bench integer compensation.
// Depends on psc_pkg, psc_req_if, psc_rsp_if and the block itself.
`timescale 1ns / 1ps
module pressure_sensor_compensation_tb;

   typedef struct packed {
      logic signed [15:0] tenths;
      logic signed [31:0] pascals;
      logic               div_err;
   } reading_type;

   class compensation_scoreboard;
      bit [63:0]   coeff_a, coeff_b;
      bit [31:0]   coeff_c;
      bit [1:0]    oss;
      reading_type expected_q[$];
      int          mismatches;

      function void reset_regs();
         coeff_a = 0;
         coeff_b = 0;
         coeff_c = 0;
         oss = 2'd3;
      endfunction

      function void write_reg(psc_pkg::csr_index_type idx, bit [63:0] data);
         case (idx)
            psc_pkg::CSR_COEFF_A: coeff_a = data;
            psc_pkg::CSR_COEFF_B: coeff_b = data;
            psc_pkg::CSR_COEFF_C: coeff_c = data[31:0];
            psc_pkg::CSR_OVERSAMPLING: oss = data[1:0];
         endcase
      endfunction

      function reading_type compensate(bit [15:0] ut_raw, bit [23:0] pr_raw);
         int ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, n;
         int ut, x1, x2, x3, b5, b6, b3, t, p, den;
         longint quo;
         bit [31:0] up, prod, b4, b7, q;
         reading_type r;
         r = '0;
         ac1 = int'($signed(coeff_a[63:48]));
         ac2 = int'($signed(coeff_a[47:32]));
         ac3 = int'($signed(coeff_a[31:16]));
         ac4 = int'(coeff_a[15:0]);
         ac5 = int'(coeff_b[63:48]);
         ac6 = int'(coeff_b[47:32]);
         b1 = int'($signed(coeff_b[31:16]));
         b2 = int'($signed(coeff_b[15:0]));
         mc = int'($signed(coeff_c[31:16]));
         md = int'($signed(coeff_c[15:0]));
         n = int'(oss);
         ut = int'(ut_raw);
         up = 32'(pr_raw) >> (8 - n);
         x1 = ((ut - ac6) * ac5) >>> 15;
         den = x1 + md;
         if (den == 0) begin
            r.div_err = 1'b1;
            return r;
         end
         quo = longint'(mc <<< 11) / longint'(den);
         x2 = int'(quo);
         b5 = x1 + x2;
         t = (b5 + 8) >>> 4;
         if (t > 32767) t = 32767;
         if (t < -32768) t = -32768;
         b6 = b5 - 4000;
         x1 = (b2 * ((b6 * b6) >>> 12)) >>> 11;
         x2 = (ac2 * b6) >>> 11;
         x3 = x1 + x2;
         b3 = ((((ac1 * 4) + x3) <<< n) + 2) >>> 2;
         x1 = (ac3 * b6) >>> 13;
         x2 = (b1 * ((b6 * b6) >>> 12)) >>> 16;
         x3 = ((x1 + x2) + 2) >>> 2;
         prod = 32'(ac4) * 32'(x3 + 32768);
         b4 = prod >> 15;
         if (b4 == 0) begin
            r.div_err = 1'b1;
            return r;
         end
         b7 = (up - 32'(b3)) * (32'd50000 >> n);
         if (b7 < 32'h8000_0000) q = (b7 << 1) / b4;
         else q = (b7 / b4) << 1;
         p = $signed(q);
         x1 = (p >>> 8) * (p >>> 8);
         x1 = (x1 * 3038) >>> 16;
         x2 = (-7357 * p) >>> 16;
         p = p + (((x1 + x2) + 3791) >>> 4);
         r.tenths = 16'(t);
         r.pascals = p;
         return r;
      endfunction

      function void note_reading(bit [15:0] ut_raw, bit [23:0] pr_raw);
         expected_q.push_back(compensate(ut_raw, pr_raw));
      endfunction

      function void check_reading(reading_type got);
         reading_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item: %p", got);
            return;
         end
         want = expected_q.pop_front();
         if (got.tenths !== want.tenths || got.pascals !== want.pascals ||
             got.div_err !== want.div_err) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected t=%0d p=%0d e=%0b, got t=%0d p=%0d e=%0b",
                        want.tenths, want.pascals, want.div_err,
                        got.tenths, got.pascals, got.div_err);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [63:0] csr_write_data;
   psc_req_if   req_ch ();
   psc_rsp_if   rsp_ch ();

   compensation_scoreboard sb = new();
   bit steady;
   int hold_requests;

   localparam bit [63:0] SheetA = {16'd408, 16'hFFB8, 16'hC7D1, 16'd32741};
   localparam bit [63:0] SheetB = {16'd32757, 16'd23153, 16'd6190, 16'd4};
   localparam bit [31:0] SheetC = {16'hDDF9, 16'd2868};

   pressure_sensor_compensation u_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // result side: random stalls plus a long hold-off on request
   initial begin
      int stall_left, seen_holds;
      reading_type got;
      stall_left = 0;
      seen_holds = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got.tenths = rsp_ch.temperature_tenths;
            got.pascals = rsp_ch.pressure_pa;
            got.div_err = rsp_ch.divide_error;
            sb.check_reading(got);
         end
         if (hold_requests != seen_holds) begin
            seen_holds = hold_requests;
            stall_left = 300;
         end else if (stall_left == 0) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic write_reg(psc_pkg::csr_index_type idx, bit [63:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      sb.write_reg(idx, data);
      @(posedge clock);
   endtask

   task automatic load_coeffs(bit [63:0] a, bit [63:0] b, bit [63:0] c, bit [63:0] o);
      write_reg(psc_pkg::CSR_COEFF_A, a);
      write_reg(psc_pkg::CSR_COEFF_B, b);
      write_reg(psc_pkg::CSR_COEFF_C, c);
      write_reg(psc_pkg::CSR_OVERSAMPLING, o);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_reading(bit [15:0] ut, bit [23:0] pr);
      int g;
      req_ch.valid <= 1'b1;
      req_ch.raw_temperature <= ut;
      req_ch.raw_pressure_bytes <= pr;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_reading(ut, pr);
      g = pick_gap();
      if (g > 0) begin
         req_ch.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (90) @(posedge clock);
   endtask

   task automatic send_directed();
      send_reading(16'h0000, 24'h000000);
      send_reading(16'hFFFF, 24'hFFFFFF);
      send_reading(16'h0000, 24'hFFFFFF);
      send_reading(16'hFFFF, 24'h000000);
      send_reading(16'd27898, 24'h5D2300);
      send_reading(16'h8000, 24'h800000);
      send_reading(16'h7FFF, 24'h7FFFFF);
   endtask

   initial begin
      bit [63:0] a, b, c;
      reset <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index <= psc_pkg::CSR_COEFF_A;
      csr_write_data <= '0;
      req_ch.valid <= 1'b0;
      req_ch.raw_temperature <= '0;
      req_ch.raw_pressure_bytes <= '0;
      steady = 0;
      hold_requests = 0;
      sb.reset_regs();
      sb.mismatches = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values: every divisor is zero
      send_directed();
      drain();
      load_coeffs(SheetA, SheetB, {32'h0, SheetC}, 64'd0);
      send_directed();
      drain();
      load_coeffs({SheetA[63:16], 16'h0}, SheetB, {32'h0, SheetC}, 64'd3);
      send_directed();
      drain();
      load_coeffs('1, '1, '1, '1);
      send_directed();
      drain();
      load_coeffs({SheetA[63:48], 16'h8000, 16'h7FFF, 16'hFFFF},
                  {16'hFFFF, 16'h0, 16'h8000, 16'h7FFF}, {32'h0, 16'h8000, 16'h7FFF}, 64'd2);
      send_directed();
      drain();

      for (int ph = 0; ph < 10; ph++) begin
         if (ph % 3 == 2) begin
            a = {$urandom, $urandom};
            b = {$urandom, $urandom};
            c = {$urandom, $urandom};
         end else begin
            a = SheetA ^ {4{8'h0, 8'($urandom)}};
            b = SheetB ^ {4{8'h0, 8'($urandom)}};
            c = {$urandom, SheetC ^ {2{8'h0, 8'($urandom)}}};
         end
         load_coeffs(a, b, c, {$urandom, $urandom} & ~64'h3 | 64'(ph % 4));
         steady = (ph == 4);
         if (ph == 6) hold_requests++;
         for (int i = 0; i < 50; i++) begin
            if (ph % 3 == 2 || $urandom_range(0, 4) == 0)
               send_reading(16'($urandom), 24'($urandom));
            else
               send_reading(16'($urandom_range(20000, 34000)),
                            24'($urandom_range(24'h400000, 24'hC00000)));
         end
         steady = 0;
         drain();
      end

      sb.mismatches += sb.expected_q.size();
      if (sb.mismatches == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
